[hw/rtl/bti_pkg.sv]
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and constants of the bilinear table interpolator: item
// commands, configuration register indexes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bti_pkg;

  localparam int CMD_W      = 2;
  localparam int INDEX_W    = 8;
  localparam int POINT_W    = 16;
  localparam int CELL_W     = 16;
  localparam int COUNT_W    = 5;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CELL_READS = 4;
  localparam int BLEND_STEPS = 3;
  localparam int PROD_W     = CELL_W + 1 + FRAC_W + 1;

  localparam logic [COUNT_W-1:0]   COUNT_RESET = 5'd16;
  localparam logic [CFG_IDX_W-1:0] CFG_X_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_COUNT = 4'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_X    = 2'd0,
    CMD_WR_Y    = 2'd1,
    CMD_WR_CELL = 2'd2,
    CMD_LOOKUP  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_LATCH,
    OP_ADDR0,
    OP_CHK0,
    OP_CHKN,
    OP_WALK,
    OP_DIV,
    OP_ROWS,
    OP_CELL,
    OP_MUL,
    OP_ADD,
    OP_RESULT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR0,
    ST_FIRST,
    ST_LAST,
    ST_WALK,
    ST_DIV,
    ST_ROWS,
    ST_CELL,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   axis_y;
  } dp_cmd_t;

  typedef struct packed {
    logic at_end;
    logic walk_stop;
    logic div_last;
    logic cell_last;
    logic blend_last;
  } dp_status_t;

endpackage

[hw/rtl/bti_if.sv]
// ----------------------------------------------------------------------------
// bti_if
// Valid/ready channels of the bilinear table interpolator: the item input,
// the result output and the configuration write port.
// ----------------------------------------------------------------------------
interface bti_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [bti_pkg::CMD_W-1:0]      cmd;
  logic        [bti_pkg::INDEX_W-1:0]    index;
  logic        [bti_pkg::POINT_W-1:0]    axis_point;
  logic signed [bti_pkg::CELL_W-1:0]     cell_value;
  logic        [bti_pkg::POINT_W-1:0]    x_in;
  logic        [bti_pkg::POINT_W-1:0]    y_in;

  modport source (output valid, cmd, index, axis_point, cell_value, x_in, y_in,
                  input ready);
  modport sink   (input valid, cmd, index, axis_point, cell_value, x_in, y_in,
                  output ready);
endinterface

interface bti_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bti_pkg::CELL_W-1:0] value_out;

  modport source (output valid, value_out, input ready);
  modport sink   (input valid, value_out, output ready);
endinterface

interface bti_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bti_pkg::CFG_IDX_W-1:0]     index;
  logic [bti_pkg::COUNT_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/bti_ram.sv]
// ----------------------------------------------------------------------------
// bti_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bti_ctrl.sv]
// ----------------------------------------------------------------------------
// bti_ctrl
// Sequencer of the interpolator: takes items, steps the datapath through
// the two axis searches, the cell reads and the three blends, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module bti_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_lookup_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  bti_pkg::dp_status_t status_i,
  output bti_pkg::dp_cmd_t    cmd_o
);

  bti_pkg::ctrl_state_e state_q, state_d;
  logic                 axis_q, axis_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bti_pkg::ST_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    cmd_o.op     = bti_pkg::OP_NONE;
    cmd_o.axis_y = axis_q;
    case (state_q)
      bti_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_lookup_i) begin
            // The X search starts here: point 0 is addressed as the
            // coordinates are captured.
            cmd_o.op     = bti_pkg::OP_LATCH;
            cmd_o.axis_y = 1'b0;
            axis_d       = 1'b0;
            state_d      = bti_pkg::ST_FIRST;
          end else begin
            cmd_o.op = bti_pkg::OP_WRITE;
          end
        end
      end
      bti_pkg::ST_ADDR0: begin
        cmd_o.op = bti_pkg::OP_ADDR0;
        state_d  = bti_pkg::ST_FIRST;
      end
      bti_pkg::ST_FIRST: begin
        cmd_o.op = bti_pkg::OP_CHK0;
        if (status_i.at_end) begin
          if (axis_q) begin
            state_d = bti_pkg::ST_ROWS;
          end else begin
            axis_d  = 1'b1;
            state_d = bti_pkg::ST_ADDR0;
          end
        end else begin
          state_d = bti_pkg::ST_LAST;
        end
      end
      bti_pkg::ST_LAST: begin
        cmd_o.op = bti_pkg::OP_CHKN;
        if (status_i.at_end) begin
          if (axis_q) begin
            state_d = bti_pkg::ST_ROWS;
          end else begin
            axis_d  = 1'b1;
            state_d = bti_pkg::ST_ADDR0;
          end
        end else begin
          state_d = bti_pkg::ST_WALK;
        end
      end
      bti_pkg::ST_WALK: begin
        cmd_o.op = bti_pkg::OP_WALK;
        if (status_i.walk_stop) begin
          state_d = bti_pkg::ST_DIV;
        end
      end
      bti_pkg::ST_DIV: begin
        cmd_o.op = bti_pkg::OP_DIV;
        if (status_i.div_last) begin
          if (axis_q) begin
            state_d = bti_pkg::ST_ROWS;
          end else begin
            axis_d  = 1'b1;
            state_d = bti_pkg::ST_ADDR0;
          end
        end
      end
      bti_pkg::ST_ROWS: begin
        cmd_o.op = bti_pkg::OP_ROWS;
        state_d  = bti_pkg::ST_CELL;
      end
      bti_pkg::ST_CELL: begin
        cmd_o.op = bti_pkg::OP_CELL;
        if (status_i.cell_last) begin
          state_d = bti_pkg::ST_MUL;
        end
      end
      bti_pkg::ST_MUL: begin
        cmd_o.op = bti_pkg::OP_MUL;
        state_d  = bti_pkg::ST_ADD;
      end
      bti_pkg::ST_ADD: begin
        cmd_o.op = bti_pkg::OP_ADD;
        state_d  = status_i.blend_last ? bti_pkg::ST_DONE : bti_pkg::ST_MUL;
      end
      bti_pkg::ST_DONE: begin
        // The result waits here while an earlier beat is still unclaimed.
        if (!out_valid_q) begin
          cmd_o.op    = bti_pkg::OP_RESULT;
          out_valid_d = 1'b1;
          state_d     = bti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bti_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/bti_datapath.sv]
// ----------------------------------------------------------------------------
// bti_datapath
// Axis and cell memories, configuration registers, the axis search
// registers, an 8-step restoring divider for the fractions and a shared
// multiply/add blend unit.
// ----------------------------------------------------------------------------
module bti_datapath #(
  parameter int MAX_X_POINTS = 16,
  parameter int MAX_Y_POINTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bti_pkg::dp_cmd_t                    cmd_i,
  output bti_pkg::dp_status_t                 status_o,
  input  logic        [bti_pkg::CMD_W-1:0]    in_cmd_i,
  input  logic        [bti_pkg::INDEX_W-1:0]  in_index_i,
  input  logic        [bti_pkg::POINT_W-1:0]  in_axis_point_i,
  input  logic signed [bti_pkg::CELL_W-1:0]   in_cell_value_i,
  input  logic        [bti_pkg::POINT_W-1:0]  in_x_i,
  input  logic        [bti_pkg::POINT_W-1:0]  in_y_i,
  input  logic                                cfg_we_i,
  input  logic        [bti_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [bti_pkg::COUNT_W-1:0]  cfg_data_i,
  output logic signed [bti_pkg::CELL_W-1:0]   value_o
);

  localparam int XAW        = (MAX_X_POINTS > 1) ? $clog2(MAX_X_POINTS) : 1;
  localparam int YAW        = (MAX_Y_POINTS > 1) ? $clog2(MAX_Y_POINTS) : 1;
  localparam int NXW        = $clog2(MAX_X_POINTS + 1);
  localparam int NYW        = $clog2(MAX_Y_POINTS + 1);
  localparam int PW         = (NXW > NYW) ? NXW : NYW;
  localparam int CELL_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int CAW        = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
  localparam int CW1        = bti_pkg::COUNT_W + 1;
  localparam int PTW        = bti_pkg::POINT_W;
  localparam int VW         = bti_pkg::CELL_W;
  localparam int FW         = bti_pkg::FRAC_W;
  localparam int PRW        = bti_pkg::PROD_W;
  localparam int IXW        = 32;

  // Configuration registers and the counts in use
  logic [bti_pkg::COUNT_W-1:0] x_count_q, y_count_q;
  logic [NXW-1:0]              nx;
  logic [NYW-1:0]              ny;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_count_q <= bti_pkg::COUNT_RESET;
      y_count_q <= bti_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bti_pkg::CFG_X_COUNT: x_count_q <= cfg_data_i;
        bti_pkg::CFG_Y_COUNT: y_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (x_count_q == '0) begin
      nx = NXW'(1);
    end else if (CW1'(x_count_q) > CW1'(MAX_X_POINTS)) begin
      nx = NXW'(MAX_X_POINTS);
    end else begin
      nx = NXW'(x_count_q);
    end
    if (y_count_q == '0) begin
      ny = NYW'(1);
    end else if (CW1'(y_count_q) > CW1'(MAX_Y_POINTS)) begin
      ny = NYW'(MAX_Y_POINTS);
    end else begin
      ny = NYW'(y_count_q);
    end
  end

  // Memories and their write side
  logic            x_we, y_we, c_we;
  logic [XAW-1:0]  x_raddr, x_last;
  logic [YAW-1:0]  y_raddr, y_last;
  logic [CAW-1:0]  c_raddr;
  logic [PTW-1:0]  x_rdata, y_rdata;
  logic [VW-1:0]   c_rdata;
  logic            is_write;

  assign is_write = (cmd_i.op == bti_pkg::OP_WRITE);
  assign x_we = is_write && (in_cmd_i == bti_pkg::CMD_WR_X)
             && (IXW'(in_index_i) < IXW'(MAX_X_POINTS));
  assign y_we = is_write && (in_cmd_i == bti_pkg::CMD_WR_Y)
             && (IXW'(in_index_i) < IXW'(MAX_Y_POINTS));
  assign c_we = is_write && (in_cmd_i == bti_pkg::CMD_WR_CELL)
             && (IXW'(in_index_i) < IXW'(CELL_DEPTH));

  bti_ram #(.WIDTH(PTW), .DEPTH(MAX_X_POINTS)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (XAW'(in_index_i)),
    .wdata_i (in_axis_point_i),
    .raddr_i (x_raddr),
    .rdata_o (x_rdata)
  );

  bti_ram #(.WIDTH(PTW), .DEPTH(MAX_Y_POINTS)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (YAW'(in_index_i)),
    .wdata_i (in_axis_point_i),
    .raddr_i (y_raddr),
    .rdata_o (y_rdata)
  );

  bti_ram #(.WIDTH(VW), .DEPTH(CELL_DEPTH)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (CAW'(in_index_i)),
    .wdata_i (in_cell_value_i),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // Axis search
  logic [PTW-1:0] x_q, y_q, lo_q, rem_q, dvs_q;
  logic [XAW-1:0] xi_q, xi2_q;
  logic [YAW-1:0] yi_q;
  logic [FW-1:0]  xf_q, yf_q;
  logic [PW-1:0]  ptr_q, ptr_p1;
  logic [2:0]     div_cnt_q;
  logic [2:0]     cell_k_q;
  logic [1:0]     step_q;
  logic           ax_y;
  logic [PTW-1:0] v, rd;
  logic           v_ge, v_le;
  logic [PTW:0]   rem_sh, rem_sub;
  logic           q_bit;
  logic [FW-1:0]  ax_frac;

  assign ax_y    = cmd_i.axis_y;
  assign v       = ax_y ? y_q : x_q;
  assign rd      = ax_y ? y_rdata : x_rdata;
  assign v_ge    = (v >= rd);
  assign v_le    = (v <= rd);
  assign ptr_p1  = ptr_q + PW'(1);
  assign x_last  = XAW'(nx - NXW'(1));
  assign y_last  = YAW'(ny - NYW'(1));
  assign ax_frac = ax_y ? yf_q : xf_q;

  // One quotient bit a cycle; the remainder stays below the divisor.
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign q_bit   = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    case (cmd_i.op)
      bti_pkg::OP_CHK0: begin
        x_raddr = x_last;
        y_raddr = y_last;
      end
      bti_pkg::OP_CHKN: begin
        x_raddr = XAW'(1);
        y_raddr = YAW'(1);
      end
      bti_pkg::OP_WALK: begin
        x_raddr = XAW'(ptr_p1);
        y_raddr = YAW'(ptr_p1);
      end
      default: begin
        x_raddr = '0;
        y_raddr = '0;
      end
    endcase
  end

  // Cell addressing
  logic [YAW+NXW-1:0] rb0_full, rb1_full;
  logic [CAW-1:0]     rb0_q, rb1_q;
  logic [YAW-1:0]     yi2;
  logic [XAW-1:0]     xi2;
  logic [NXW-1:0]     xi_p1;
  logic [NYW-1:0]     yi_p1;

  assign xi_p1    = NXW'(xi_q) + NXW'(1);
  assign yi_p1    = NYW'(yi_q) + NYW'(1);
  assign xi2      = (xi_p1 < nx) ? XAW'(xi_p1) : xi_q;
  assign yi2      = (yi_p1 < ny) ? YAW'(yi_p1) : yi_q;
  assign rb0_full = yi_q * nx;
  assign rb1_full = yi2 * nx;

  always_comb begin
    case (cell_k_q[1:0])
      2'd0:    c_raddr = CAW'(rb0_q + CAW'(xi_q));
      2'd1:    c_raddr = CAW'(rb0_q + CAW'(xi2_q));
      2'd2:    c_raddr = CAW'(rb1_q + CAW'(xi_q));
      default: c_raddr = CAW'(rb1_q + CAW'(xi2_q));
    endcase
  end

  // Blend unit: a + ((b - a) * f) / 256, the division truncating toward zero
  logic signed [VW-1:0]  cells_q [bti_pkg::CELL_READS];
  logic signed [VW-1:0]  low_q, high_q, res_q, value_q;
  logic signed [VW-1:0]  bl_a, bl_b;
  logic        [FW-1:0]  bl_f;
  logic signed [VW:0]    diff;
  logic signed [PRW-1:0] prod_d, prod_q, quot;
  logic signed [VW+1:0]  sum;
  logic [1:0]            cell_wi;

  always_comb begin
    case (step_q)
      2'd0: begin
        bl_a = cells_q[0];
        bl_b = cells_q[1];
        bl_f = xf_q;
      end
      2'd1: begin
        bl_a = cells_q[2];
        bl_b = cells_q[3];
        bl_f = xf_q;
      end
      default: begin
        bl_a = low_q;
        bl_b = high_q;
        bl_f = yf_q;
      end
    endcase
  end

  assign diff    = {bl_b[VW-1], bl_b} - {bl_a[VW-1], bl_a};
  assign prod_d  = diff * $signed({1'b0, bl_f});
  assign quot    = prod_q[PRW-1] ? ((prod_q + PRW'(255)) >>> 8) : (prod_q >>> 8);
  assign sum     = {{2{bl_a[VW-1]}}, bl_a} + quot[VW+1:0];
  assign cell_wi = 2'(cell_k_q - 3'd1);

  // Sequencing counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      div_cnt_q <= '0;
      cell_k_q  <= '0;
      step_q    <= '0;
    end else begin
      case (cmd_i.op)
        bti_pkg::OP_CHKN: ptr_q <= PW'(1);
        bti_pkg::OP_WALK: begin
          if (v_ge) begin
            ptr_q <= ptr_p1;
          end else begin
            div_cnt_q <= '0;
          end
        end
        bti_pkg::OP_DIV:  div_cnt_q <= div_cnt_q + 3'd1;
        bti_pkg::OP_ROWS: begin
          cell_k_q <= '0;
          step_q   <= '0;
        end
        bti_pkg::OP_CELL: cell_k_q <= cell_k_q + 3'd1;
        bti_pkg::OP_ADD:  step_q <= step_q + 2'd1;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      bti_pkg::OP_LATCH: begin
        x_q <= in_x_i;
        y_q <= in_y_i;
      end
      bti_pkg::OP_CHK0: begin
        if (v_le) begin
          if (ax_y) begin
            yi_q <= '0;
            yf_q <= '0;
          end else begin
            xi_q <= '0;
            xf_q <= '0;
          end
        end else begin
          lo_q <= rd;
        end
      end
      bti_pkg::OP_CHKN: begin
        if (ax_y) begin
          yi_q <= v_ge ? y_last : '0;
          yf_q <= '0;
        end else begin
          xi_q <= v_ge ? x_last : '0;
          xf_q <= '0;
        end
      end
      bti_pkg::OP_WALK: begin
        if (v_ge) begin
          lo_q <= rd;
          if (ax_y) begin
            yi_q <= YAW'(ptr_q);
          end else begin
            xi_q <= XAW'(ptr_q);
          end
        end else begin
          rem_q <= v - lo_q;
          dvs_q <= rd - lo_q;
        end
      end
      bti_pkg::OP_DIV: begin
        rem_q <= q_bit ? rem_sub[PTW-1:0] : rem_sh[PTW-1:0];
        if (ax_y) begin
          yf_q <= {ax_frac[FW-2:0], q_bit};
        end else begin
          xf_q <= {ax_frac[FW-2:0], q_bit};
        end
      end
      bti_pkg::OP_ROWS: begin
        rb0_q <= CAW'(rb0_full);
        rb1_q <= CAW'(rb1_full);
        xi2_q <= xi2;
      end
      bti_pkg::OP_CELL: begin
        if (cell_k_q != 3'd0) begin
          cells_q[cell_wi] <= c_rdata;
        end
      end
      bti_pkg::OP_MUL: prod_q <= prod_d;
      bti_pkg::OP_ADD: begin
        case (step_q)
          2'd0:    low_q  <= sum[VW-1:0];
          2'd1:    high_q <= sum[VW-1:0];
          default: res_q  <= sum[VW-1:0];
        endcase
      end
      bti_pkg::OP_RESULT: value_q <= res_q;
      default: ;
    endcase
  end

  assign status_o.at_end     = (cmd_i.op == bti_pkg::OP_CHK0) ? v_le : v_ge;
  assign status_o.walk_stop  = !v_ge;
  assign status_o.div_last   = (div_cnt_q == 3'(FW - 1));
  assign status_o.cell_last  = (cell_k_q == 3'(bti_pkg::CELL_READS));
  assign status_o.blend_last = (step_q == 2'(bti_pkg::BLEND_STEPS - 1));
  assign value_o             = value_q;

endmodule

[hw/rtl/bilinear_table_interpolator.sv]
// ----------------------------------------------------------------------------
// bilinear_table_interpolator
// Holds an X axis, a Y axis and a row-major table of signed 16-bit cells in
// three RAMs, loaded by write items that give no beat and leave the block
// ready for the next item. A lookup item gives one beat: the four cells
// around the point are blended along X on two rows and then along Y. Each
// axis is first checked against its first and its last point; a coordinate
// between them is found by a walk through its RAM at one point per cycle,
// followed by a restoring divider for the 8-bit fraction. After both
// searches come the cell addressing, the four cell reads, the three blends
// and the hand-over to the output register. Axis points and cells must be
// written before a lookup reads them. A finished result waits in an output
// register, so new items are taken while it is unclaimed. The counts are
// written through the configuration port, register 0 for X and register 1
// for Y; the user must write them only while no lookup is in flight, as the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator #(
  parameter int MAX_X_POINTS = 16,
  parameter int MAX_Y_POINTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bti_in_if.sink    in_i,
  bti_out_if.source out_o,
  bti_cfg_if.sink   cfg_i
);

  bti_pkg::dp_cmd_t    dp_cmd;
  bti_pkg::dp_status_t dp_status;
  logic                in_lookup;

  assign in_lookup   = (in_i.cmd == bti_pkg::CMD_LOOKUP);
  assign cfg_i.ready = 1'b1;

  bti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_lookup_i (in_lookup),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  bti_datapath #(
    .MAX_X_POINTS (MAX_X_POINTS),
    .MAX_Y_POINTS (MAX_Y_POINTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .in_cmd_i        (in_i.cmd),
    .in_index_i      (in_i.index),
    .in_axis_point_i (in_i.axis_point),
    .in_cell_value_i (in_i.cell_value),
    .in_x_i          (in_i.x_in),
    .in_y_i          (in_i.y_in),
    .cfg_we_i        (cfg_i.valid && cfg_i.ready),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .value_o         (out_o.value_out)
  );

  // The output register is only reloaded once the previous beat has gone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.op == bti_pkg::OP_RESULT) |-> !out_o.valid)
    else $error("result register reloaded while a beat was pending");

  // An accepted lookup occupies the block for the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_lookup) |=> !in_i.ready)
    else $error("item accepted straight after a lookup");

  // A beat appears only as a completed lookup publishes its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(dp_cmd.op == bti_pkg::OP_RESULT))
    else $error("result valid rose without a finished lookup");

endmodule
